// File: design/msva_pkg.sv
// ---------------------------------------------------------------------------
// msva_pkg: shared types and microcode for the mesh volume accumulator
// Holds the control word layout, the datapath control bundle, the result
// bundle and the read-only program that sequences one triangle.
// ---------------------------------------------------------------------------
`default_nettype none

package msva_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int SUM_W          = 64;
    localparam int MAG_W          = 63;
    localparam int NUM_STEPS      = 15;
    localparam int STEP_W         = $clog2(NUM_STEPS);

    // Multiplier operand pairs. The b*c pairs build a cross product term,
    // the a*t pairs scale the finished term by one coordinate of a.
    typedef enum logic [3:0] {
        M_NONE = 4'd0,
        M_B1C2 = 4'd1,
        M_B2C1 = 4'd2,
        M_B2C0 = 4'd3,
        M_B0C2 = 4'd4,
        M_B0C1 = 4'd5,
        M_B1C0 = 4'd6,
        M_A0T  = 4'd7,
        M_A1T  = 4'd8,
        M_A2T  = 4'd9
    } msel_t;

    // Operation applied to the product registered in the previous step.
    typedef enum logic [2:0] {
        A_NOP    = 3'd0,
        A_T_LOAD = 3'd1,
        A_T_SUB  = 3'd2,
        A_D_LOAD = 3'd3,
        A_D_ADD  = 3'd4
    } alu_t;

    typedef struct packed {
        msel_t msel;
        alu_t  alu;
        logic  acc;          // saturating add of the determinant into the sum
        logic  emit;         // hand the result to the output register, clear sum
        logic  fin;          // last step of the program
        logic  fin_if_more;  // jump back to idle unless the item closes the mesh
    } uword_t;

    typedef struct packed {
        msel_t msel;
        alu_t  alu;
        logic  acc;
        logic  clr;
    } dp_ctl_t;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             sat;
    } res_t;

    function automatic uword_t ucode(input logic [STEP_W-1:0] step);
        uword_t w;
        w = '{msel: M_NONE, alu: A_NOP, acc: 1'b0, emit: 1'b0, fin: 1'b0,
              fin_if_more: 1'b0};
        unique case (step)
            4'd0:  w.msel = M_B1C2;
            4'd1:
            begin
                w.msel = M_B2C1;
                w.alu  = A_T_LOAD;
            end
            4'd2:  w.alu = A_T_SUB;
            4'd3:  w.msel = M_A0T;
            4'd4:
            begin
                w.msel = M_B2C0;
                w.alu  = A_D_LOAD;
            end
            4'd5:
            begin
                w.msel = M_B0C2;
                w.alu  = A_T_LOAD;
            end
            4'd6:  w.alu = A_T_SUB;
            4'd7:  w.msel = M_A1T;
            4'd8:
            begin
                w.msel = M_B0C1;
                w.alu  = A_D_ADD;
            end
            4'd9:
            begin
                w.msel = M_B1C0;
                w.alu  = A_T_LOAD;
            end
            4'd10: w.alu = A_T_SUB;
            4'd11: w.msel = M_A2T;
            4'd12: w.alu = A_D_ADD;
            4'd13:
            begin
                w.acc         = 1'b1;
                w.fin_if_more = 1'b1;
            end
            4'd14:
            begin
                w.emit = 1'b1;
                w.fin  = 1'b1;
            end
            default: w.fin = 1'b1;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: design/mesh_signed_volume_accumulator_core.sv
// ---------------------------------------------------------------------------
// mesh_signed_volume_accumulator_core: signed mesh volume accumulator
// Sums the triple product a . (b x c) of each triangle into a saturating
// 64-bit accumulator and emits the magnitude when the last face arrives.
// ---------------------------------------------------------------------------
// Each triangle runs a 15-step microprogram on one shared multiplier.
// A face that does not close the mesh ends its program at step 13 and then
// raises s_tready again; a closing face runs on through the emit step 14.
// The emit step of the closing face registers the result item for m_tvalid.
// A waiting result stalls only the emit step of the next closing face.
// rst_n clears the sequencer, the output valid, the sum and the overflow flag.
`default_nettype none

module mesh_signed_volume_accumulator_core #(
    parameter  int COORD_BITS = msva_pkg::COORD_BITS_DEF,
    localparam int IN_W       = ((9 * COORD_BITS + 7) / 8) * 8
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output      logic            s_tready,
    // ax, ay, az, bx, by_coord, bz, cx, cy, cz; COORD_BITS each, zero padded
    input  wire logic [IN_W-1:0] s_tdata,
    input  wire logic            s_tlast,    // last_face
    output      logic            m_tvalid,
    input  wire logic            m_tready,
    // volume_times_six [62:0], zero at bit 63
    output      logic [63:0]     m_tdata,
    // saturated
    output      logic            m_tuser
);

    logic                         busy_reg;
    logic [msva_pkg::STEP_W-1:0]  step_reg;
    logic                         last_reg;
    logic                         out_valid_reg;
    logic [msva_pkg::MAG_W-1:0]   out_mag_reg;
    logic                         out_sat_reg;

    msva_pkg::uword_t  uw;
    msva_pkg::dp_ctl_t ctl;
    msva_pkg::res_t    res;
    logic              accept;
    logic              go;
    logic              finish;

    assign uw     = msva_pkg::ucode(step_reg);
    assign accept = s_tvalid && s_tready;
    // The emit step waits while the previous result is still unclaimed.
    assign go     = busy_reg && !(uw.emit && out_valid_reg && !m_tready);
    assign finish = uw.fin || (uw.fin_if_more && !last_reg);

    always_comb
    begin
        ctl.msel = go ? uw.msel : msva_pkg::M_NONE;
        ctl.alu  = go ? uw.alu : msva_pkg::A_NOP;
        ctl.acc  = go && uw.acc;
        ctl.clr  = go && uw.emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (accept)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (go)
        begin
            if (finish)
            begin
                busy_reg <= 1'b0;
                step_reg <= '0;
            end
            else
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            last_reg <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.clr)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.clr)
        begin
            out_mag_reg <= res.mag;
            out_sat_reg <= res.sat;
        end
    end

    msva_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept),
        .coords (s_tdata[9*COORD_BITS-1:0]),
        .ctl    (ctl),
        .res    (res)
    );

    assign s_tready = !busy_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_mag_reg};
    assign m_tuser  = out_sat_reg;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg && step_reg == '0)
        else $error("accepted item did not start the program at its first step");

    a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && uw.emit && out_valid_reg && !m_tready) |=> $stable(step_reg) && busy_reg)
        else $error("emit step advanced while the output register was full");

    a_emit_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && uw.emit) |-> last_reg)
        else $error("emit step reached for a face that does not close the mesh");

    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ctl.clr))
        else $error("result valid rose without an emit step");
`endif

endmodule

`default_nettype wire

// File: design/msva_datapath.sv
// ---------------------------------------------------------------------------
// msva_datapath: shared multiplier, determinant registers and accumulator
// One signed multiplier is steered by the control bundle; a cross product
// term builds up in t, the determinant in d, and the mesh sum saturates.
// ---------------------------------------------------------------------------
`default_nettype none

module msva_datapath #(
    parameter int COORD_BITS = msva_pkg::COORD_BITS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    load,
    input  wire logic [9*COORD_BITS-1:0] coords,
    input  wire msva_pkg::dp_ctl_t       ctl,
    output msva_pkg::res_t               res
);

    localparam int CB = COORD_BITS;
    localparam int TW = 2 * CB + 1;   // one cross product component
    localparam int PW = TW + CB;      // multiplier output
    localparam int DW = 3 * CB + 2;   // determinant
    localparam int SW = msva_pkg::SUM_W;

    // Coordinates in item order: ax ay az bx by bz cx cy cz.
    logic signed [CB-1:0] crd_reg [9];
    logic signed [TW-1:0] t_reg;
    logic signed [PW-1:0] p_reg;
    logic signed [DW-1:0] d_reg;
    logic signed [SW-1:0] sum_reg;
    logic                 ovf_reg;

    logic signed [TW-1:0] mul_x;
    logic signed [CB-1:0] mul_y;
    logic signed [PW-1:0] prod;
    logic signed [SW-1:0] d_ext;
    logic        [SW:0]   sum_wide;
    logic                 sum_ovf;
    logic signed [SW-1:0] sum_neg;
    logic                 sum_is_min;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < 9; i++)
            begin
                crd_reg[i] <= coords[i*CB +: CB];
            end
        end
    end

    always_comb
    begin
        mul_x = '0;
        mul_y = '0;
        unique case (ctl.msel)
            msva_pkg::M_NONE:
            begin
                mul_x = '0;
                mul_y = '0;
            end
            msva_pkg::M_B1C2:
            begin
                mul_x = TW'(crd_reg[4]);
                mul_y = crd_reg[8];
            end
            msva_pkg::M_B2C1:
            begin
                mul_x = TW'(crd_reg[5]);
                mul_y = crd_reg[7];
            end
            msva_pkg::M_B2C0:
            begin
                mul_x = TW'(crd_reg[5]);
                mul_y = crd_reg[6];
            end
            msva_pkg::M_B0C2:
            begin
                mul_x = TW'(crd_reg[3]);
                mul_y = crd_reg[8];
            end
            msva_pkg::M_B0C1:
            begin
                mul_x = TW'(crd_reg[3]);
                mul_y = crd_reg[7];
            end
            msva_pkg::M_B1C0:
            begin
                mul_x = TW'(crd_reg[4]);
                mul_y = crd_reg[6];
            end
            msva_pkg::M_A0T:
            begin
                mul_x = t_reg;
                mul_y = crd_reg[0];
            end
            msva_pkg::M_A1T:
            begin
                mul_x = t_reg;
                mul_y = crd_reg[1];
            end
            msva_pkg::M_A2T:
            begin
                mul_x = t_reg;
                mul_y = crd_reg[2];
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    assign prod = mul_x * mul_y;

    always_ff @(posedge clk)
    begin
        p_reg <= prod;
        unique case (ctl.alu)
            msva_pkg::A_NOP:    ;
            msva_pkg::A_T_LOAD: t_reg <= p_reg[TW-1:0];
            msva_pkg::A_T_SUB:  t_reg <= t_reg - p_reg[TW-1:0];
            msva_pkg::A_D_LOAD: d_reg <= DW'(p_reg);
            msva_pkg::A_D_ADD:  d_reg <= d_reg + DW'(p_reg);
            default:            ;
        endcase
    end

    // Overflow shows as a mismatch of the two top bits of the widened sum.
    assign d_ext    = SW'(d_reg);
    assign sum_wide = {sum_reg[SW-1], sum_reg} + {d_ext[SW-1], d_ext};
    assign sum_ovf  = sum_wide[SW] != sum_wide[SW-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (ctl.clr)
        begin
            sum_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (ctl.acc)
        begin
            if (sum_ovf)
            begin
                sum_reg <= sum_wide[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
                ovf_reg <= 1'b1;
            end
            else
            begin
                sum_reg <= sum_wide[SW-1:0];
            end
        end
    end

    // The most negative sum has no 63-bit magnitude; it reports the maximum.
    assign sum_neg    = -sum_reg;
    assign sum_is_min = sum_reg == {1'b1, {(SW-1){1'b0}}};

    always_comb
    begin
        if (sum_is_min)
        begin
            res.mag = {msva_pkg::MAG_W{1'b1}};
            res.sat = 1'b1;
        end
        else
        begin
            res.mag = sum_reg[SW-1] ? sum_neg[msva_pkg::MAG_W-1:0]
                                    : sum_reg[msva_pkg::MAG_W-1:0];
            res.sat = ovf_reg;
        end
    end

endmodule

`default_nettype wire

// File: tb/tb_mesh_signed_volume_accumulator_core.sv
// ---------------------------------------------------------------------------
// tb_mesh_signed_volume_accumulator_core: self-checking testbench
// Streams triangles into the accumulator and checks each emitted mesh volume
// against a local model of the saturating determinant sum, or a typed row's
// value. Directed rows and random meshes in several idling phases drive it.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_mesh_signed_volume_accumulator_core;

    localparam int     CW          = msva_pkg::COORD_BITS_DEF;
    localparam int     IN_W        = ((9 * CW + 7) / 8) * 8;
    localparam int     NUM_ROWS    = 16;
    localparam int     PHASE_ITEMS = 100;
    localparam int     STALL_LIMIT = 2000;
    localparam longint SUM_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam longint SUM_MIN     = 64'h8000_0000_0000_0000;
    localparam logic [msva_pkg::MAG_W-1:0] MAG_FULL = '1;

    typedef logic signed [CW-1:0] coord_t;

    // The first vertex sits in the low bits, matching the tdata layout.
    typedef struct packed {
        coord_t cz, cy, cx, bz, by_coord, bx, az, ay, ax;
    } tri_t;

    typedef struct packed {
        tri_t           face;
        logic           last;
        logic           typed;
        msva_pkg::res_t want;
    } stim_row_t;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             s_tlast;
    logic             m_tvalid;
    logic             m_tready;
    logic [63:0]      m_tdata;
    logic             m_tuser;

    longint         mesh_sum;
    logic           mesh_overflow;
    msva_pkg::res_t pending_volumes[$];
    int             err_count;
    int             send_idle_pct;
    int             recv_stall_pct;

    mesh_signed_volume_accumulator_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint tri_det(input tri_t t);
        longint ax, ay, az, bx, by, bz, cx, cy, cz;
        ax = longint'(t.ax);
        ay = longint'(t.ay);
        az = longint'(t.az);
        bx = longint'(t.bx);
        by = longint'(t.by_coord);
        bz = longint'(t.bz);
        cx = longint'(t.cx);
        cy = longint'(t.cy);
        cz = longint'(t.cz);
        return ax * (by * cz - bz * cy) + ay * (bz * cx - bx * cz)
             + az * (bx * cy - by * cx);
    endfunction

    // Adds one face to the running mesh sum; returns 1 when the face closes
    // the mesh and a volume comes out.
    function automatic logic accumulate_face(input tri_t t, input logic last,
                                             output msva_pkg::res_t vol);
        longint     d;
        logic [64:0] wide;
        d    = tri_det(t);
        wide = {mesh_sum[63], mesh_sum} + {d[63], d};
        vol  = '0;
        if (wide[64] != wide[63])
        begin
            mesh_sum      = wide[64] ? SUM_MIN : SUM_MAX;
            mesh_overflow = 1'b1;
        end
        else
        begin
            mesh_sum = wide[63:0];
        end
        if (!last)
            return 1'b0;
        vol.sat = mesh_overflow;
        // The magnitude of the most negative sum does not fit in 63 bits.
        if (mesh_sum == SUM_MIN)
        begin
            vol.mag = MAG_FULL;
            vol.sat = 1'b1;
        end
        else if (mesh_sum < 0)
        begin
            vol.mag = msva_pkg::MAG_W'(-mesh_sum);
        end
        else
        begin
            vol.mag = msva_pkg::MAG_W'(mesh_sum);
        end
        mesh_sum      = 0;
        mesh_overflow = 1'b0;
        return 1'b1;
    endfunction

    function automatic stim_row_t mk_row(input int ax, ay, az, bx, by, bz,
                                         cx, cy, cz, input logic last,
                                         input logic typed,
                                         input logic [msva_pkg::MAG_W-1:0] mag,
                                         input logic sat);
        stim_row_t r;
        r.face     = '{cz: coord_t'(cz), cy: coord_t'(cy), cx: coord_t'(cx),
                       bz: coord_t'(bz), by_coord: coord_t'(by),
                       bx: coord_t'(bx), az: coord_t'(az), ay: coord_t'(ay),
                       ax: coord_t'(ax)};
        r.last     = last;
        r.typed    = typed;
        r.want.mag = mag;
        r.want.sat = sat;
        return r;
    endfunction

    function automatic coord_t rand_coord();
        case ($urandom_range(9))
            0: return coord_t'(-32768);
            1: return coord_t'(32767);
            2: return '0;
            3, 4: return coord_t'($urandom_range(31)) - coord_t'(16);
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic tri_t rand_face();
        tri_t t;
        t.ax       = rand_coord();
        t.ay       = rand_coord();
        t.az       = rand_coord();
        t.bx       = rand_coord();
        t.by_coord = rand_coord();
        t.bz       = rand_coord();
        t.cx       = rand_coord();
        t.cy       = rand_coord();
        t.cz       = rand_coord();
        return t;
    endfunction

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic send_face(input tri_t t, input logic last, input logic typed,
                             input msva_pkg::res_t want);
        msva_pkg::res_t vol;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'(t);
        s_tlast  <= last;
        do @(negedge clk); while (!s_tready);
        @(posedge clk);
        if (accumulate_face(t, last, vol))
            pending_volumes.push_back(typed ? want : vol);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h",
                 $realtime, what, got, want);
        err_count++;
    endtask

    // Outputs are sampled at the falling edge, where nothing is in motion.
    always @(negedge clk)
    begin
        msva_pkg::res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_volumes.size() == 0)
            begin
                report_mismatch("unexpected volume item", m_tdata, 64'd0);
            end
            else
            begin
                want = pending_volumes.pop_front();
                if (m_tdata !== {1'b0, want.mag})
                    report_mismatch("volume_times_six", m_tdata, {1'b0, want.mag});
                if (m_tuser !== want.sat)
                    report_mismatch("saturated", 64'(m_tuser), 64'(want.sat));
            end
        end
    end

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(negedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("no item moved for %0d cycles", STALL_LIMIT);
        $display("** mesh_signed_volume_accumulator_core: FAILED **");
        $finish;
    end

    initial
    begin
        stim_row_t      directed_rows [NUM_ROWS];
        int             idle_pcts [4][2];
        int             sent;
        int             mesh_len;
        msva_pkg::res_t no_want;

        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        mesh_sum       = 0;
        mesh_overflow  = 1'b0;
        err_count      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        no_want        = '0;
        idle_pcts      = '{'{0, 0}, '{77, 0}, '{0, 77}, '{26, 26}};

        directed_rows = '{
            // Zero triangle right after reset.
            mk_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0),
            // Unit cube corner, positive and then negative orientation.
            mk_row(1, 0, 0, 0, 1, 0, 0, 0, 1, 1, 1, 1, 0),
            mk_row(0, 1, 0, 1, 0, 0, 0, 0, 1, 1, 1, 1, 0),
            // Largest magnitude pattern of extreme coordinates.
            mk_row(32767, 32767, 32767, 32767, -32768, 32767,
                   32767, 32767, -32768, 1, 0, 0, 0),
            // Degenerate triangles at both extremes.
            mk_row(-32768, -32768, -32768, -32768, -32768, -32768,
                   -32768, -32768, -32768, 1, 1, 0, 0),
            mk_row(32767, 32767, 32767, 32767, 32767, 32767,
                   32767, 32767, 32767, 1, 1, 0, 0),
            // A face and its mirror cancel within one mesh.
            mk_row(5, -3, 7, 1200, -45, 9, -300, 77, 4096, 0, 0, 0, 0),
            mk_row(5, -3, 7, -300, 77, 4096, 1200, -45, 9, 1, 1, 0, 0),
            // Two identical vertices.
            mk_row(100, 200, 300, -7, 8, 9, -7, 8, 9, 1, 1, 0, 0),
            // Diagonal of most negative values.
            mk_row(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768, 1, 1,
                   63'd35184372088832, 0),
            mk_row(32767, 0, 0, 0, 32767, 0, 0, 0, 32767, 1, 0, 0, 0),
            // A three-face mesh with mixed signs.
            mk_row(-1, 2, -3, 4, -5, 6, 7, 8, -9, 0, 0, 0, 0),
            mk_row(32767, -32768, 1, -1, 0, 32767, 12345, -23456, 345, 0, 0, 0, 0),
            mk_row(-20000, 15000, -10000, 5000, -2500, 1250, 625, -312, 156,
                   1, 0, 0, 0),
            mk_row(-1, -1, -1, 1, -1, 1, -1, 1, 1, 1, 0, 0, 0),
            mk_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0)
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_face(directed_rows[i].face, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].want);

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = idle_pcts[p][0];
            recv_stall_pct = idle_pcts[p][1];
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                mesh_len = ($urandom_range(7) == 0) ? $urandom_range(4, 12)
                                                    : $urandom_range(1, 3);
                for (int k = 0; k < mesh_len; k++)
                    send_face(rand_face(), k == mesh_len - 1, 1'b0, no_want);
                sent += mesh_len;
            end
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (pending_volumes.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (err_count == 0)
            $display("** mesh_signed_volume_accumulator_core: PASSED **");
        else
            $display("** mesh_signed_volume_accumulator_core: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
